// ===== sv/scrpx_pkg.sv =====
`timescale 1ns / 1ps

package scrpx_pkg;

    localparam int ATTR_CELLS_DEF = 768;

    localparam logic [15:0] BITMAP_LO = 16'h4000;
    localparam logic [15:0] ATTR_LO   = 16'h5800;
    localparam logic [15:0] AREA_END  = 16'h5B00;

    localparam logic [15:0] BLUE_BASE_RST  = 16'd12;
    localparam logic [15:0] RED_BASE_RST   = 16'd24576;
    localparam logic [15:0] GREEN_BASE_RST = 16'd768;
    localparam logic [5:0]  OFFSET_X_RST   = 6'd32;
    localparam logic [5:0]  OFFSET_Y_RST   = 6'd24;

    localparam int TDATA_IN_W  = 24;
    localparam int TDATA_OUT_W = 40;

    typedef enum logic [2:0] {
        REG_BLUE_BASE  = 3'd0,
        REG_RED_BASE   = 3'd1,
        REG_GREEN_BASE = 3'd2,
        REG_OFFSET_X   = 3'd3,
        REG_OFFSET_Y   = 3'd4,
        REG_MONO_MODE  = 3'd5
    } cfg_index_t;

    // One decoded bitmap byte, ready to be sent out as eight pixels.
    typedef struct packed {
        logic [8:0]  x_start;
        logic [7:0]  y;
        logic [15:0] ink;
        logic [15:0] paper;
        logic [7:0]  bits;
    } pix_run_t;

    function automatic logic [15:0] mix_color(input logic [2:0] sel, input logic [15:0] b,
                                              input logic [15:0] r, input logic [15:0] g);
        logic [15:0] c;
        c = 16'd0;
        if (sel[0])
        begin
            c = c | b;
        end
        if (sel[1])
        begin
            c = c | r;
        end
        if (sel[2])
        begin
            c = c | g;
        end
        return c;
    endfunction

endpackage

// ===== sv/scrpx_ram.sv =====
`timescale 1ns / 1ps

module scrpx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 768
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// ===== sv/scrpx_serializer.sv =====
`timescale 1ns / 1ps

module scrpx_serializer
    import scrpx_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  pix_run_t               run,
    output logic                   load_ready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,  // pixel_x[8:0], pixel_y[16:9], color[32:17]
    output logic                   m_tlast
);

    logic        valid_reg, valid_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [8:0]  x_reg, x_next;
    logic [7:0]  y_reg, y_next;
    logic [15:0] ink_reg, ink_next;
    logic [15:0] paper_reg, paper_next;
    logic [7:0]  bits_reg, bits_next;
    logic        beat;
    logic        at_end;
    logic [15:0] color;

    assign at_end     = (cnt_reg == 3'd7);
    assign beat       = valid_reg && m_tready;
    assign load_ready = !valid_reg || (m_tready && at_end);

    always_comb
    begin
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        ink_next   = ink_reg;
        paper_next = paper_reg;
        bits_next  = bits_reg;
        if (beat)
        begin
            cnt_next  = cnt_reg + 3'd1;
            x_next    = x_reg + 9'd1;
            bits_next = {bits_reg[6:0], 1'b0};
            if (at_end)
            begin
                valid_next = 1'b0;
            end
        end
        if (load && load_ready)
        begin
            valid_next = 1'b1;
            cnt_next   = 3'd0;
            x_next     = run.x_start;
            y_next     = run.y;
            ink_next   = run.ink;
            paper_next = run.paper;
            bits_next  = run.bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= 3'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        ink_reg   <= ink_next;
        paper_reg <= paper_next;
        bits_reg  <= bits_next;
    end

    assign color    = bits_reg[7] ? ink_reg : paper_reg;
    assign m_tvalid = valid_reg;
    assign m_tlast  = at_end;
    assign m_tdata  = {7'd0, color, y_reg, x_reg};

endmodule

// ===== sv/screen_write_to_rgb565_pixels.sv =====
`timescale 1ns / 1ps

// Snoops CPU memory writes and turns screen writes into RGB565 pixels. Each
// beat on s_axis is one observed write. Attribute writes (0x5800-0x5AFF) are
// stored and give no output; bitmap writes (0x4000-0x57FF) give a run of
// eight pixel beats, data bit 7 first, with tlast on the eighth; all other
// addresses are accepted and dropped. The one-pixel-per-beat serializer is
// fed by a two-stage input pipeline (decode, then attribute memory read);
// input beats are still taken while a run drains, until a bitmap write
// has to wait in stage one. After reset the attribute memory is cleared one
// cell per cycle, all ATTR_CELLS cells, during which s_tready is low;
// configuration writes are taken at any time and should be made only
// while the block is idle.

module screen_write_to_rgb565_pixels
    import scrpx_pkg::*;
#(
    parameter int ATTR_CELLS = ATTR_CELLS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,  // bus_address[15:0], bus_data[23:16]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,  // pixel_x[8:0], pixel_y[16:9], color[32:17]
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [15:0]            cfg_data
);

    localparam int CELL_W = $clog2(ATTR_CELLS);

    logic [15:0] blue_base_reg, red_base_reg, green_base_reg;
    logic [5:0]  offset_x_reg, offset_y_reg;
    logic        mono_mode_reg;

    logic              clearing_reg, clearing_next;
    logic [CELL_W-1:0] clr_cnt_reg, clr_cnt_next;

    logic        s1_valid_reg, s1_valid_next;
    logic        s1_is_attr_reg, s1_is_attr_next;
    logic [15:0] s1_addr_reg, s1_addr_next;
    logic [7:0]  s1_data_reg, s1_data_next;

    logic        s2_valid_reg, s2_valid_next;
    logic [15:0] s2_addr_reg, s2_addr_next;
    logic [7:0]  s2_data_reg, s2_data_next;

    logic [15:0] in_addr;
    logic [7:0]  in_data;
    logic        in_beat;
    logic        in_bitmap;
    logic        in_attr;
    logic        s1_go;
    logic        s2_go;
    logic        ser_ready;

    logic              ram_en;
    logic              ram_we;
    logic [CELL_W-1:0] ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    logic [1:0]  third;
    logic [7:0]  row;
    logic [15:0] b_sel, r_sel, g_sel;
    pix_run_t    run;

    assign in_addr   = s_tdata[15:0];
    assign in_data   = s_tdata[23:16];
    assign in_bitmap = (in_addr >= BITMAP_LO) && (in_addr < ATTR_LO);
    assign in_attr   = (in_addr >= ATTR_LO) && (in_addr < AREA_END);
    assign in_beat   = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blue_base_reg  <= BLUE_BASE_RST;
            red_base_reg   <= RED_BASE_RST;
            green_base_reg <= GREEN_BASE_RST;
            offset_x_reg   <= OFFSET_X_RST;
            offset_y_reg   <= OFFSET_Y_RST;
            mono_mode_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BLUE_BASE:  blue_base_reg  <= cfg_data;
                REG_RED_BASE:   red_base_reg   <= cfg_data;
                REG_GREEN_BASE: green_base_reg <= cfg_data;
                REG_OFFSET_X:   offset_x_reg   <= cfg_data[5:0];
                REG_OFFSET_Y:   offset_y_reg   <= cfg_data[5:0];
                REG_MONO_MODE:  mono_mode_reg  <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Attribute writes leave stage one freely; bitmap writes wait for room in stage two.
    assign s2_go    = s2_valid_reg && ser_ready;
    assign s1_go    = s1_valid_reg && (s1_is_attr_reg || !s2_valid_reg || s2_go);
    assign s_tready = !clearing_reg && (!s1_valid_reg || s1_go);

    always_comb
    begin
        clearing_next   = clearing_reg;
        clr_cnt_next    = clr_cnt_reg;
        s1_valid_next   = s1_valid_reg;
        s1_is_attr_next = s1_is_attr_reg;
        s1_addr_next    = s1_addr_reg;
        s1_data_next    = s1_data_reg;
        s2_valid_next   = s2_valid_reg;
        s2_addr_next    = s2_addr_reg;
        s2_data_next    = s2_data_reg;

        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + CELL_W'(1);
            if (clr_cnt_reg == CELL_W'(ATTR_CELLS - 1))
            begin
                clearing_next = 1'b0;
            end
        end

        if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        if (in_beat)
        begin
            s1_valid_next   = in_bitmap || in_attr;
            s1_is_attr_next = in_attr;
            s1_addr_next    = in_addr;
            s1_data_next    = in_data;
        end

        if (s2_go)
        begin
            s2_valid_next = 1'b0;
        end
        if (s1_go && !s1_is_attr_reg)
        begin
            s2_valid_next = 1'b1;
            s2_addr_next  = s1_addr_reg;
            s2_data_next  = s1_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_cnt_reg  <= clr_cnt_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_is_attr_reg <= s1_is_attr_next;
        s1_addr_reg    <= s1_addr_next;
        s1_data_reg    <= s1_data_next;
        s2_addr_reg    <= s2_addr_next;
        s2_data_reg    <= s2_data_next;
    end

    // Outside the clear after reset, the attribute memory is touched only when stage
    // one hands its item on, so the read data stays put while stage two is stalled.
    always_comb
    begin
        ram_en    = s1_go;
        ram_we    = s1_is_attr_reg;
        ram_wdata = s1_data_reg;
        if (s1_is_attr_reg)
        begin
            ram_addr = CELL_W'(s1_addr_reg[9:0]);
        end
        else
        begin
            ram_addr = CELL_W'({s1_addr_reg[12:11], s1_addr_reg[7:0]});
        end
        if (clearing_reg)
        begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = clr_cnt_reg;
            ram_wdata = 8'd0;
        end
    end

    scrpx_ram #(
        .WIDTH(8),
        .DEPTH(ATTR_CELLS)
    ) u_attr_ram (
        .clk  (clk),
        .en   (ram_en),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign third = s2_addr_reg[12:11];
    assign row   = {third, s2_addr_reg[7:5], s2_addr_reg[10:8]};
    assign b_sel = ram_rdata[6] ? {blue_base_reg[14:0], 1'b0} : blue_base_reg;
    assign r_sel = ram_rdata[6] ? {red_base_reg[14:0], 1'b0} : red_base_reg;
    assign g_sel = ram_rdata[6] ? {green_base_reg[14:0], 1'b0} : green_base_reg;

    always_comb
    begin
        run.x_start = {1'b0, s2_addr_reg[4:0], 3'd0} + {3'd0, offset_x_reg};
        run.y       = row + {2'd0, offset_y_reg};
        run.bits    = s2_data_reg;
        if (mono_mode_reg)
        begin
            run.ink   = 16'd0;
            run.paper = red_base_reg | green_base_reg | blue_base_reg;
        end
        else
        begin
            run.ink   = mix_color(ram_rdata[2:0], b_sel, r_sel, g_sel);
            run.paper = mix_color(ram_rdata[5:3], b_sel, r_sel, g_sel);
        end
    end

    scrpx_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s2_valid_reg),
        .run       (run),
        .load_ready(ser_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s_tready)
    else $error("input beat accepted during attribute clear");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_go) |-> !(s1_go && !s1_is_attr_reg))
    else $error("bitmap item overran a stalled read stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("pixel run ended before its last beat");

endmodule
